[rtl/core/kca_pkg.sv]
// ----------------------------------------------------------------------------
// kca_pkg
// Shared types and constants of the keyframe color animator.
// ----------------------------------------------------------------------------
package kca_pkg;

    localparam int DivStages   = 32;
    localparam int DivWidth    = 32;
    localparam int DvsWidth    = 17;
    localparam int RandomShift = 6;

    // floor(x / 100) == (x * PctRecip) >> PctShift for every x below 2**23.
    localparam logic [23:0] PctRecip = 24'd10737419;
    localparam int          PctShift = 30;

    localparam logic [2:0] RegRepeat  = 3'd0;
    localparam logic [2:0] RegRandom  = 3'd1;
    localparam logic [2:0] RegKey2Pct = 3'd2;
    localparam logic [2:0] RegKey3Pct = 3'd3;
    localparam logic [2:0] RegKey4Pct = 3'd4;
    localparam logic [2:0] RegKey0Rgb = 3'd5;
    localparam logic [2:0] RegKey1Rgb = 3'd6;
    localparam logic [2:0] RegKey2Rgb = 3'd7;

    typedef struct packed {
        logic [7:0]  repeat_count;
        logic        random_start;
        logic [6:0]  key2_percent;
        logic [6:0]  key3_percent;
        logic [6:0]  key4_percent;
        logic [47:0] key0_rgb;
        logic [47:0] key1_rgb;
        logic [47:0] key2_rgb;
    } cfg_t;

endpackage

[rtl/core/keyframe_color_animator.sv]
// ----------------------------------------------------------------------------
// keyframe_color_animator
// Three-key piecewise linear color gradient for one particle color track.
// ----------------------------------------------------------------------------
// One particle beat is accepted every clock cycle while the output does not
// stall; its color passes through three pipelined 32-stage dividers in
// series (period, position modulo period, interpolation), plus seven further
// registered stages. A stall on the output holds the whole pipe.
module keyframe_color_animator
(
    input  logic        clk,
    input  logic        rst_n,
    input  logic        s_tvalid,
    output logic        s_tready,
    input  logic [63:0] s_tdata,   // age[15:0], life_length[31:16], random_word[63:32]
    output logic        m_tvalid,
    input  logic        m_tready,
    output logic [47:0] m_tdata,   // red[15:0], green[31:16], blue[47:32]
    input  logic        psel,
    input  logic        penable,
    input  logic        pwrite,
    input  logic [5:0]  paddr,
    input  logic [63:0] pwdata,
    output logic [63:0] prdata,
    output logic        pready
);

    localparam int Ds = kca_pkg::DivStages;

    typedef struct packed {
        logic [15:0] age;
        logic [15:0] life;
        logic [31:0] rnd;
    } sb1_t;

    typedef struct packed {
        logic [15:0] period;
        logic        neg;
    } sb2_t;

    typedef struct packed {
        logic [15:0] a;
        logic        neg;
    } sb3_t;

    kca_pkg::cfg_t cfg;
    logic          en;

    kca_regs u_regs
    (
        .clk     (clk),
        .rst_n   (rst_n),
        .psel    (psel),
        .penable (penable),
        .pwrite  (pwrite),
        .paddr   (paddr),
        .pwdata  (pwdata),
        .prdata  (prdata),
        .pready  (pready),
        .cfg     (cfg)
    );

    assign en       = ~m_tvalid | m_tready;
    assign s_tready = en;

    // Input stage.
    logic       v0_reg;
    sb1_t       in_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            v0_reg <= 1'b0;
        else if (en)
            v0_reg <= s_tvalid;
    end

    always_ff @(posedge clk)
    begin
        if (en)
            in_reg <= {s_tdata[15:0], s_tdata[31:16], s_tdata[63:32]};
    end

    // Period division.
    logic [7:0]  reps;
    logic [31:0] q1;
    logic [16:0] r1;
    logic        v1_reg [Ds];
    sb1_t        sb1_reg[Ds];

    assign reps = (cfg.repeat_count != 8'd0) ? cfg.repeat_count : 8'd1;

    kca_div u_div_period
    (
        .clk       (clk),
        .en        (en),
        .dividend  ({16'd0, in_reg.life}),
        .divisor   ({9'd0, reps}),
        .quotient  (q1),
        .remainder (r1)
    );

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            for (int i = 0; i < Ds; i++)
                v1_reg[i] <= 1'b0;
        end
        else if (en)
        begin
            for (int i = 0; i < Ds; i++)
                v1_reg[i] <= (i == 0) ? v0_reg : v1_reg[(i == 0) ? 0 : i-1];
        end
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            for (int i = 0; i < Ds; i++)
                sb1_reg[i] <= (i == 0) ? in_reg : sb1_reg[(i == 0) ? 0 : i-1];
        end
    end

    // Position stage.
    sb1_t        sb1_last;
    logic [15:0] period_next;
    logic [27:0] pos_sum;
    logic        v2_reg;
    logic [15:0] period_reg;
    logic [26:0] mag_reg;
    logic        neg_reg;

    assign sb1_last = sb1_reg[Ds-1];

    always_comb
    begin
        if (q1[15:0] != 16'd0)
            period_next = q1[15:0];
        else if (sb1_last.life != 16'd0)
            period_next = sb1_last.life;
        else
            period_next = 16'd1;
        pos_sum = {12'd0, sb1_last.age}
                + (cfg.random_start ? {2'd0, sb1_last.rnd[31:kca_pkg::RandomShift]} : 28'd0);
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            v2_reg <= 1'b0;
        else if (en)
            v2_reg <= v1_reg[Ds-1];
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            period_reg <= period_next;
            neg_reg    <= (pos_sum == 28'd0);
            mag_reg    <= (pos_sum == 28'd0) ? 27'd1 : 27'(pos_sum - 28'd1);
        end
    end

    // Modulo division.
    logic [31:0] q2;
    logic [16:0] r2;
    logic        v3_reg [Ds];
    sb2_t        sb2_reg[Ds];

    kca_div u_div_mod
    (
        .clk       (clk),
        .en        (en),
        .dividend  ({5'd0, mag_reg}),
        .divisor   ({1'b0, period_reg}),
        .quotient  (q2),
        .remainder (r2)
    );

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            for (int i = 0; i < Ds; i++)
                v3_reg[i] <= 1'b0;
        end
        else if (en)
        begin
            for (int i = 0; i < Ds; i++)
                v3_reg[i] <= (i == 0) ? v2_reg : v3_reg[(i == 0) ? 0 : i-1];
        end
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            for (int i = 0; i < Ds; i++)
                sb2_reg[i] <= (i == 0) ? {period_reg, neg_reg}
                                       : sb2_reg[(i == 0) ? 0 : i-1];
        end
    end

    // Key time products.
    sb2_t               sb2_last;
    logic               v4_reg;
    logic signed [17:0] pos4_reg;
    logic [22:0]        prod2_reg, prod3_reg, prod4_reg;

    assign sb2_last = sb2_reg[Ds-1];

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            v4_reg <= 1'b0;
        else if (en)
            v4_reg <= v3_reg[Ds-1];
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            pos4_reg  <= sb2_last.neg ? -$signed({2'b00, r2[15:0]})
                                      : $signed({2'b00, r2[15:0]});
            prod2_reg <= cfg.key2_percent * sb2_last.period;
            prod3_reg <= cfg.key3_percent * sb2_last.period;
            prod4_reg <= cfg.key4_percent * sb2_last.period;
        end
    end

    // Key times, divided by one hundred through the reciprocal.
    logic               v5_reg;
    logic signed [17:0] pos5_reg;
    logic [16:0]        t2_reg, t3_reg, t4_reg;
    logic [46:0]        m2, m3, m4;

    assign m2 = prod2_reg * kca_pkg::PctRecip;
    assign m3 = prod3_reg * kca_pkg::PctRecip;
    assign m4 = prod4_reg * kca_pkg::PctRecip;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            v5_reg <= 1'b0;
        else if (en)
            v5_reg <= v4_reg;
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            pos5_reg <= pos4_reg;
            t2_reg   <= m2[kca_pkg::PctShift +: 17];
            t3_reg   <= m3[kca_pkg::PctShift +: 17];
            t4_reg   <= m4[kca_pkg::PctShift +: 17];
        end
    end

    // Segment selection.
    logic               v6_reg;
    logic [47:0]        ka_reg, kb_reg;
    logic [15:0]        num_reg;
    logic [16:0]        den_reg;
    logic signed [17:0] st2, st3, st4;
    logic signed [17:0] d_lo;
    logic [47:0]        ka_next, kb_next;
    logic [15:0]        num_next;
    logic [16:0]        den_next;

    assign st2 = $signed({1'b0, t2_reg});
    assign st3 = $signed({1'b0, t3_reg});
    assign st4 = $signed({1'b0, t4_reg});

    always_comb
    begin
        d_lo = '0;
        priority if (pos5_reg < st2)
        begin
            ka_next  = cfg.key0_rgb;
            kb_next  = cfg.key0_rgb;
            num_next = 16'd0;
            den_next = 17'd1;
        end
        else if (pos5_reg < st3)
        begin
            d_lo     = pos5_reg - st2;
            ka_next  = cfg.key0_rgb;
            kb_next  = cfg.key1_rgb;
            num_next = d_lo[15:0];
            den_next = 17'(t3_reg - t2_reg);
        end
        else if (pos5_reg < st4)
        begin
            d_lo     = pos5_reg - st3;
            ka_next  = cfg.key1_rgb;
            kb_next  = cfg.key2_rgb;
            num_next = d_lo[15:0];
            den_next = 17'(t4_reg - t3_reg);
        end
        else
        begin
            ka_next  = cfg.key2_rgb;
            kb_next  = cfg.key2_rgb;
            num_next = 16'd0;
            den_next = 17'd1;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            v6_reg <= 1'b0;
        else if (en)
            v6_reg <= v5_reg;
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            ka_reg  <= ka_next;
            kb_reg  <= kb_next;
            num_reg <= num_next;
            den_reg <= den_next;
        end
    end

    // Channel products.
    logic        v7_reg;
    logic [31:0] prod_reg[3];
    sb3_t        ch_reg  [3];
    logic [16:0] den7_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            v7_reg <= 1'b0;
        else if (en)
            v7_reg <= v6_reg;
    end

    always_ff @(posedge clk)
    begin
        logic [15:0] ca, cb;
        logic        lower;
        logic [15:0] mag;
        if (en)
        begin
            for (int c = 0; c < 3; c++)
            begin
                ca          = ka_reg[32 - 16*c +: 16];
                cb          = kb_reg[32 - 16*c +: 16];
                lower       = cb < ca;
                mag         = lower ? 16'(ca - cb) : 16'(cb - ca);
                prod_reg[c] <= mag * num_reg;
                ch_reg[c]   <= {ca, lower};
            end
            den7_reg <= den_reg;
        end
    end

    // Interpolation divisions.
    logic [31:0] q3[3];
    logic [16:0] r3[3];
    logic        v8_reg [Ds];
    sb3_t        sb3_reg[Ds][3];

    for (genvar c = 0; c < 3; c++)
    begin : g_lerp
        kca_div u_div_lerp
        (
            .clk       (clk),
            .en        (en),
            .dividend  (prod_reg[c]),
            .divisor   (den7_reg),
            .quotient  (q3[c]),
            .remainder (r3[c])
        );
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            for (int i = 0; i < Ds; i++)
                v8_reg[i] <= 1'b0;
        end
        else if (en)
        begin
            for (int i = 0; i < Ds; i++)
                v8_reg[i] <= (i == 0) ? v7_reg : v8_reg[(i == 0) ? 0 : i-1];
        end
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            for (int i = 0; i < Ds; i++)
                for (int c = 0; c < 3; c++)
                    sb3_reg[i][c] <= (i == 0) ? ch_reg[c] : sb3_reg[(i == 0) ? 0 : i-1][c];
        end
    end

    // Output stage.
    logic        vout_reg;
    logic [47:0] out_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            vout_reg <= 1'b0;
        else if (en)
            vout_reg <= v8_reg[Ds-1];
    end

    always_ff @(posedge clk)
    begin
        sb3_t s;
        if (en)
        begin
            for (int c = 0; c < 3; c++)
            begin
                s = sb3_reg[Ds-1][c];
                out_reg[16*c +: 16] <= s.neg ? 16'(s.a - q3[c][15:0])
                                             : 16'(s.a + q3[c][15:0]);
            end
        end
    end

    assign m_tvalid = vout_reg;
    assign m_tdata  = out_reg;

endmodule

[rtl/core/kca_regs.sv]
// ----------------------------------------------------------------------------
// kca_regs
// Configuration register file behind the APB port.
// ----------------------------------------------------------------------------
module kca_regs
(
    input  logic                clk,
    input  logic                rst_n,
    input  logic                psel,
    input  logic                penable,
    input  logic                pwrite,
    input  logic [5:0]          paddr,
    input  logic [63:0]         pwdata,
    output logic [63:0]         prdata,
    output logic                pready,
    output kca_pkg::cfg_t       cfg
);

    kca_pkg::cfg_t cfg_reg;
    logic          wr_en;

    assign pready = 1'b1;
    assign wr_en  = psel & penable & pwrite;
    assign cfg    = cfg_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cfg_reg.repeat_count <= 8'd1;
            cfg_reg.random_start <= 1'b0;
            cfg_reg.key2_percent <= 7'd0;
            cfg_reg.key3_percent <= 7'd50;
            cfg_reg.key4_percent <= 7'd100;
            cfg_reg.key0_rgb     <= 48'd0;
            cfg_reg.key1_rgb     <= 48'd0;
            cfg_reg.key2_rgb     <= 48'd0;
        end
        else if (wr_en)
        begin
            unique case (paddr[5:3])
                kca_pkg::RegRepeat:  cfg_reg.repeat_count <= pwdata[7:0];
                kca_pkg::RegRandom:  cfg_reg.random_start <= pwdata[0];
                kca_pkg::RegKey2Pct: cfg_reg.key2_percent <= pwdata[6:0];
                kca_pkg::RegKey3Pct: cfg_reg.key3_percent <= pwdata[6:0];
                kca_pkg::RegKey4Pct: cfg_reg.key4_percent <= pwdata[6:0];
                kca_pkg::RegKey0Rgb: cfg_reg.key0_rgb     <= pwdata[47:0];
                kca_pkg::RegKey1Rgb: cfg_reg.key1_rgb     <= pwdata[47:0];
                kca_pkg::RegKey2Rgb: cfg_reg.key2_rgb     <= pwdata[47:0];
                default: ;
            endcase
        end
    end

    always_comb
    begin
        unique case (paddr[5:3])
            kca_pkg::RegRepeat:  prdata = {56'd0, cfg_reg.repeat_count};
            kca_pkg::RegRandom:  prdata = {63'd0, cfg_reg.random_start};
            kca_pkg::RegKey2Pct: prdata = {57'd0, cfg_reg.key2_percent};
            kca_pkg::RegKey3Pct: prdata = {57'd0, cfg_reg.key3_percent};
            kca_pkg::RegKey4Pct: prdata = {57'd0, cfg_reg.key4_percent};
            kca_pkg::RegKey0Rgb: prdata = {16'd0, cfg_reg.key0_rgb};
            kca_pkg::RegKey1Rgb: prdata = {16'd0, cfg_reg.key1_rgb};
            kca_pkg::RegKey2Rgb: prdata = {16'd0, cfg_reg.key2_rgb};
            default:             prdata = 64'd0;
        endcase
    end

endmodule

[rtl/core/kca_div.sv]
// ----------------------------------------------------------------------------
// kca_div
// Pipelined restoring divider, one quotient bit per stage, unsigned.
// ----------------------------------------------------------------------------
module kca_div
(
    input  logic                              clk,
    input  logic                              en,
    input  logic [kca_pkg::DivWidth-1:0]      dividend,
    input  logic [kca_pkg::DvsWidth-1:0]      divisor,
    output logic [kca_pkg::DivWidth-1:0]      quotient,
    output logic [kca_pkg::DvsWidth-1:0]      remainder
);

    logic [kca_pkg::DvsWidth-1:0] rem_reg  [kca_pkg::DivStages];
    logic [kca_pkg::DivWidth-1:0] work_reg [kca_pkg::DivStages];
    logic [kca_pkg::DvsWidth-1:0] dvs_reg  [kca_pkg::DivStages];
    logic [kca_pkg::DvsWidth-1:0] rem_next [kca_pkg::DivStages];
    logic [kca_pkg::DivWidth-1:0] work_next[kca_pkg::DivStages];

    always_comb
    begin
        logic [kca_pkg::DvsWidth-1:0] rem_in;
        logic [kca_pkg::DivWidth-1:0] work_in;
        logic [kca_pkg::DvsWidth-1:0] dvs_in;
        logic [kca_pkg::DvsWidth:0]   shifted;
        logic                         ge;
        for (int i = 0; i < kca_pkg::DivStages; i++)
        begin
            if (i == 0)
            begin
                rem_in  = '0;
                work_in = dividend;
                dvs_in  = divisor;
            end
            else
            begin
                rem_in  = rem_reg[i-1];
                work_in = work_reg[i-1];
                dvs_in  = dvs_reg[i-1];
            end
            shifted      = {rem_in, work_in[kca_pkg::DivWidth-1]};
            ge           = shifted >= {1'b0, dvs_in};
            rem_next[i]  = ge ? kca_pkg::DvsWidth'(shifted - {1'b0, dvs_in})
                              : shifted[kca_pkg::DvsWidth-1:0];
            work_next[i] = {work_in[kca_pkg::DivWidth-2:0], ge};
        end
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            for (int i = 0; i < kca_pkg::DivStages; i++)
            begin
                rem_reg[i]  <= rem_next[i];
                work_reg[i] <= work_next[i];
                dvs_reg[i]  <= (i == 0) ? divisor : dvs_reg[(i == 0) ? 0 : i-1];
            end
        end
    end

    assign quotient  = work_reg[kca_pkg::DivStages-1];
    assign remainder = rem_reg[kca_pkg::DivStages-1];

endmodule
